[hw/rtl/ckb_pkg.sv]
// Shared types, codes and CRC-16/ARC helper functions for the chained-key block codec.
package ckb_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned WinN    = 4;
  localparam int unsigned FillW   = 3;
  localparam int unsigned BurstW  = 3;

  localparam logic [StatusW-1:0] ST_RUN  = 2'd0;
  localparam logic [StatusW-1:0] ST_OK   = 2'd1;
  localparam logic [StatusW-1:0] ST_FAIL = 2'd2;

  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_MODE      = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_START_KEY = 1'd1;

  localparam logic [KeyW-1:0] CRC_XOR_ALL = 16'hffff;

  localparam logic [KeyW-1:0] NIB_TAB [16] = '{
    16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
    16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
  };

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_in_block;
    logic             restart_chain;
  } ckb_item_t;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               end_of_block;
    logic [StatusW-1:0] status;
  } ckb_res_t;

  typedef struct packed {
    logic             req;
    logic [KeyW-1:0]  crc;
    logic [ByteW-1:0] kb;
  } ckb_trl_t;

  function automatic logic [KeyW-1:0] crc_nib(input logic [KeyW-1:0] c,
                                               input logic [3:0] nib);
    logic [KeyW-1:0] r;
    r = NIB_TAB[c[3:0]];
    return {4'h0, c[KeyW-1:4]} ^ r ^ NIB_TAB[nib];
  endfunction

  function automatic logic [KeyW-1:0] crc_byte(input logic [KeyW-1:0] c,
                                                input logic [ByteW-1:0] b);
    logic [KeyW-1:0] t;
    t = crc_nib(c, b[3:0]);
    return crc_nib(t, b[7:4]);
  endfunction

endpackage

[hw/rtl/ckb_in_reg.sv]
// Input register stage that holds one accepted byte until the core consumes it.
module ckb_in_reg
  import ckb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ckb_item_t in_item_i,
  input  logic      take_i,
  output logic      valid_o,
  output ckb_item_t item_o
);

  logic      valid_q;
  logic      valid_d;
  ckb_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/ckb_core.sv]
// Chaining key, CRC accumulator and trailer window with the per-byte scramble and check.
module ckb_core
  import ckb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  ckb_item_t       item_i,
  input  logic            mode_i,
  input  logic [KeyW-1:0] start_key_i,
  output ckb_res_t        res_o,
  output ckb_trl_t        trl_o
);

  logic [KeyW-1:0]  chain_key_q, chain_key_d;
  logic [KeyW-1:0]  crc_q, crc_d;
  logic             inside_q, inside_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [ByteW-1:0] win_q [WinN];
  logic [ByteW-1:0] win_d [WinN];

  logic [KeyW-1:0]  key_eff;
  logic [ByteW-1:0] kb;
  logic [KeyW-1:0]  crc_base;
  logic [FillW-1:0] fill_base;
  logic [ByteW-1:0] win_base [WinN];
  logic             do_crc;
  logic [ByteW-1:0] crc_in;
  logic [KeyW-1:0]  crc_next;
  logic [ByteW-1:0] dec_byte;
  logic [ByteW-1:0] enc_byte;
  logic [KeyW-1:0]  lo_half;
  logic [KeyW-1:0]  hi_half;
  logic [KeyW:0]    half_sum;

  always_comb begin
    key_eff   = item_i.restart_chain ? start_key_i : chain_key_q;
    kb        = key_eff[ByteW-1:0];
    crc_base  = inside_q ? crc_q : key_eff;
    fill_base = inside_q ? fill_q : '0;
    for (int i = 0; i < WinN; i++) begin
      win_base[i] = inside_q ? win_q[i] : '0;
    end
    dec_byte = item_i.data_byte - kb;
    enc_byte = item_i.data_byte + kb;
    do_crc   = (mode_i == MODE_ENCODE) || fill_base[FillW-1];
    crc_in   = (mode_i == MODE_ENCODE) ? item_i.data_byte : win_base[0];
    crc_next = do_crc ? crc_byte(crc_base, crc_in) : crc_base;

    chain_key_d = key_eff;
    crc_d       = crc_next;
    fill_d      = fill_base;
    inside_d    = !item_i.last_in_block;
    for (int i = 0; i < WinN; i++) begin
      win_d[i] = win_base[i];
    end
    res_o    = '{out_byte: enc_byte, end_of_block: 1'b0, status: ST_RUN};
    trl_o    = '{req: 1'b0, crc: crc_next, kb: kb};
    lo_half  = '0;
    hi_half  = '0;
    half_sum = '0;

    if (mode_i == MODE_DECODE) begin
      res_o.out_byte = dec_byte;
      if (fill_base[FillW-1]) begin
        win_d[0] = win_base[1];
        win_d[1] = win_base[2];
        win_d[2] = win_base[3];
        win_d[3] = dec_byte;
      end else begin
        win_d[fill_base[1:0]] = dec_byte;
        fill_d = fill_base + 1'b1;
      end
      lo_half  = {win_d[1], win_d[0]};
      hi_half  = {win_d[3], win_d[2]};
      half_sum = {1'b0, lo_half} + {1'b0, hi_half};
      if (item_i.last_in_block) begin
        res_o.end_of_block = 1'b1;
        res_o.status       = ST_FAIL;
        fill_d             = '0;
        if (fill_base[FillW-1] || (fill_base == FillW'(WinN - 1))) begin
          chain_key_d = lo_half;
          if ((lo_half == crc_next) && (half_sum == {1'b0, CRC_XOR_ALL})) begin
            res_o.status = ST_OK;
          end
        end
      end
    end else if (item_i.last_in_block) begin
      trl_o.req   = 1'b1;
      chain_key_d = crc_next;
      fill_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_key_q <= '0;
      crc_q       <= '0;
      inside_q    <= 1'b0;
      fill_q      <= '0;
      for (int i = 0; i < WinN; i++) begin
        win_q[i] <= '0;
      end
    end else if (advance_i) begin
      chain_key_q <= chain_key_d;
      crc_q       <= crc_d;
      inside_q    <= inside_d;
      fill_q      <= fill_d;
      for (int i = 0; i < WinN; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

[hw/rtl/ckb_out.sv]
// Result register with the four-byte trailer sequencer used when encoding.
module ckb_out
  import ckb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  ckb_res_t res_i,
  input  ckb_trl_t trl_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output ckb_res_t out_res_o,
  output logic     can_load_o,
  output logic     busy_o
);

  logic              valid_q;
  ckb_res_t          res_q;
  ckb_res_t          trl_res;
  logic [BurstW-1:0] cnt_q;
  logic [KeyW-1:0]   crc_q;
  logic [KeyW-1:0]   crc_inv;
  logic [ByteW-1:0]  kb_q;
  logic              burst_step;

  assign can_load_o = !valid_q || out_ready_i;
  assign busy_o     = (cnt_q != '0);
  assign burst_step = busy_o && can_load_o;
  assign crc_inv    = CRC_XOR_ALL - crc_q;

  always_comb begin
    trl_res = '{out_byte: '0, end_of_block: 1'b0, status: ST_RUN};
    unique case (cnt_q)
      3'd4:    trl_res.out_byte = crc_q[7:0] + kb_q;
      3'd3:    trl_res.out_byte = crc_q[15:8] + kb_q;
      3'd2:    trl_res.out_byte = crc_inv[7:0] + kb_q;
      3'd1: begin
        trl_res.out_byte     = crc_inv[15:8] + kb_q;
        trl_res.end_of_block = 1'b1;
        trl_res.status       = ST_OK;
      end
      default: trl_res.out_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (advance_i) begin
      valid_q <= 1'b1;
      if (trl_i.req) begin
        cnt_q <= BurstW'(WinN);
      end
    end else if (burst_step) begin
      valid_q <= 1'b1;
      cnt_q   <= cnt_q - 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      res_q <= res_i;
      if (trl_i.req) begin
        crc_q <= trl_i.crc;
        kb_q  <= trl_i.kb;
      end
    end else if (burst_step) begin
      res_q <= trl_res;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

[hw/rtl/chained_key_block_codec_crc16.sv]
// Top level of the chained-key block codec with CRC-16/ARC trailer.
//
//   Channel   Dir  Handshake                  Payload
//   s_axis    in   s_axis_tvalid/tready       tdata data_byte, tlast, tuser restart_chain
//   m_axis    out  m_axis_tvalid/tready       tdata out_byte, tlast, tuser status
//   cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One byte per cycle is accepted and one result per cycle is delivered while
// m_axis is ready and no trailer is pending. Encoding the last byte of a block
// adds four trailer bytes from the result register's sequencer, during which
// the input register holds its byte. Bytes pass the input and result registers.
// Reset clears the key, CRC, window, block state and configuration at once.
// Backpressure on m_axis stalls the result register and then the input register.
module chained_key_block_codec_crc16
  import ckb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,
  input  logic               s_axis_tuser,   // [0] restart_chain
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata,   // [7:0] out_byte
  output logic               m_axis_tlast,
  output logic [StatusW-1:0] m_axis_tuser,   // [1:0] status
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic            mode_q;
  logic [KeyW-1:0] start_key_q;
  logic            in_valid;
  ckb_item_t       in_item;
  ckb_item_t       item_q;
  logic            advance;
  logic            can_load;
  logic            busy;
  ckb_res_t        core_res;
  ckb_trl_t        core_trl;
  ckb_res_t        out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_DECODE;
      start_key_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:      mode_q      <= cfg_data_i[0];
        REG_START_KEY: start_key_q <= cfg_data_i[KeyW-1:0];
        default:       mode_q      <= mode_q;
      endcase
    end
  end

  assign in_item = '{data_byte: s_axis_tdata, last_in_block: s_axis_tlast,
                     restart_chain: s_axis_tuser};
  assign advance = in_valid && can_load && !busy;

  ckb_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (advance),
    .valid_o    (in_valid),
    .item_o     (item_q)
  );

  ckb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item_q),
    .mode_i      (mode_q),
    .start_key_i (start_key_q),
    .res_o       (core_res),
    .trl_o       (core_trl)
  );

  ckb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .res_i       (core_res),
    .trl_i       (core_trl),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .can_load_o  (can_load),
    .busy_o      (busy)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tlast = out_res.end_of_block;
  assign m_axis_tuser = out_res.status;

  a_eob_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser != ST_RUN))
    else $error("block end delivered without a final status");

  a_mid_block_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == ST_RUN))
    else $error("status reported before the end of a block");

  a_burst_from_encode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(advance && (mode_q == MODE_ENCODE) && item_q.last_in_block))
    else $error("trailer sequence started without an encoded block end");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the chained-key block codec with CRC-16/ARC trailer.
module tb_top;
  import ckb_pkg::*;

  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 8;
  localparam int RandomItems  = 470;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ByteW-1:0]   m_axis_tdata;
  logic               m_axis_tlast;
  logic [StatusW-1:0] m_axis_tuser;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;

  chained_key_block_codec_crc16 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ckb_item_t pending_bytes [$];
  ckb_res_t  predicted_out [$];
  int        bytes_in_flight = 0;
  int        errors = 0;
  logic      s_took = 1'b0;
  int        s_gap = 0;
  int        m_stall = 0;
  bit        calm = 1'b0;

  // Predictor state.
  logic            mode_r = MODE_DECODE;
  logic [KeyW-1:0] start_r = '0;
  logic [KeyW-1:0] key_r = '0;
  logic [KeyW-1:0] crc_r = '0;
  bit              blk_open = 1'b0;
  logic [7:0]      win_r [4];
  int              fill_r = 0;

  // Stimulus-side view of the chaining key, used to build blocks that pass the check.
  logic            cur_mode = MODE_DECODE;
  logic [KeyW-1:0] cur_start = '0;
  logic [KeyW-1:0] gen_key = '0;
  bit              key_known = 1'b1;
  int              stim_count = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_arc(input logic [15:0] c, input logic [7:0] b);
    c ^= {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: %s got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic expect_byte(input logic [7:0] b, input logic eob, input logic [1:0] st);
    ckb_res_t r;
    r.out_byte = b;
    r.end_of_block = eob;
    r.status = st;
    predicted_out.push_back(r);
  endtask

  task automatic scramble_and_check(input ckb_item_t it);
    logic [7:0]  kb;
    logic [7:0]  b;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [16:0] sum;
    logic [1:0]  st;
    if (it.restart_chain) begin
      key_r = start_r;
    end
    kb = key_r[7:0];
    if (!blk_open) begin
      blk_open = 1'b1;
      crc_r = key_r;
      fill_r = 0;
      for (int i = 0; i < 4; i++) begin
        win_r[i] = 8'h00;
      end
    end
    if (mode_r == MODE_DECODE) begin
      b = it.data_byte - kb;
      if (fill_r >= 4) begin
        crc_r = crc16_arc(crc_r, win_r[0]);
        win_r[0] = win_r[1];
        win_r[1] = win_r[2];
        win_r[2] = win_r[3];
        win_r[3] = b;
      end else begin
        win_r[fill_r] = b;
        fill_r++;
      end
      if (!it.last_in_block) begin
        expect_byte(b, 1'b0, ST_RUN);
      end else begin
        st = ST_FAIL;
        if (fill_r >= 4) begin
          lo = {win_r[1], win_r[0]};
          hi = {win_r[3], win_r[2]};
          sum = {1'b0, lo} + {1'b0, hi};
          if (lo == crc_r && sum == 17'h0ffff) begin
            st = ST_OK;
          end
          key_r = lo;
        end
        expect_byte(b, 1'b1, st);
        blk_open = 1'b0;
        fill_r = 0;
      end
    end else begin
      b = it.data_byte + kb;
      crc_r = crc16_arc(crc_r, it.data_byte);
      expect_byte(b, 1'b0, ST_RUN);
      if (it.last_in_block) begin
        hi = CRC_XOR_ALL - crc_r;
        expect_byte(crc_r[7:0] + kb, 1'b0, ST_RUN);
        expect_byte(crc_r[15:8] + kb, 1'b0, ST_RUN);
        expect_byte(hi[7:0] + kb, 1'b0, ST_RUN);
        expect_byte(hi[15:8] + kb, 1'b1, ST_OK);
        key_r = crc_r;
        blk_open = 1'b0;
        fill_r = 0;
      end
    end
  endtask

  always @(negedge clk_i) begin
    ckb_item_t it;
    if ($urandom_range(0, 199) == 0) begin
      calm <= !calm;
    end
    if (rst_ni && (!s_axis_tvalid || s_took)) begin
      if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        it = pending_bytes.pop_front();
        s_axis_tdata <= it.data_byte;
        s_axis_tlast <= it.last_in_block;
        s_axis_tuser <= it.restart_chain;
        s_axis_tvalid <= 1'b1;
        s_gap <= pick_idle();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (m_stall > 0) begin
      m_stall <= m_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 9) < 3) begin
        m_stall <= pick_idle();
      end
    end
  end

  always @(posedge clk_i) begin
    ckb_res_t want;
    ckb_item_t it;
    s_took <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_out.size() == 0) begin
          report_mismatch("result with nothing expected, out_byte", m_axis_tdata, 0);
        end else begin
          want = predicted_out.pop_front();
          if (m_axis_tdata !== want.out_byte) begin
            report_mismatch("out_byte", m_axis_tdata, want.out_byte);
          end
          if (m_axis_tlast !== want.end_of_block) begin
            report_mismatch("end_of_block", m_axis_tlast, want.end_of_block);
          end
          if (m_axis_tuser !== want.status) begin
            report_mismatch("status", m_axis_tuser, want.status);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MODE:      mode_r = cfg_data_i[0];
          REG_START_KEY: start_r = cfg_data_i;
          default:       ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.data_byte = s_axis_tdata;
        it.last_in_block = s_axis_tlast;
        it.restart_chain = s_axis_tuser;
        scramble_and_check(it);
        bytes_in_flight--;
      end
    end
  end

  always @(posedge clk_i) begin
    int idle_cycles;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i); while (bytes_in_flight != 0 || predicted_out.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MODE) begin
      cur_mode = val[0];
    end else begin
      cur_start = val;
    end
  endtask

  task automatic push_bytes(input logic [7:0] raw [$], input int rs, input bit close);
    logic [15:0] k;
    logic [15:0] crc;
    logic [7:0]  dec [$];
    bit          known;
    int          n;
    ckb_item_t   it;
    k = gen_key;
    crc = gen_key;
    known = key_known || (rs == 0);
    n = raw.size();
    for (int i = 0; i < n; i++) begin
      if (i == rs) begin
        k = cur_start;
      end
      if (i == 0) begin
        crc = k;
      end
      dec.push_back(raw[i] - k[7:0]);
      if (cur_mode == MODE_ENCODE) begin
        crc = crc16_arc(crc, raw[i]);
      end
      it.data_byte = raw[i];
      it.last_in_block = close && (i == n - 1);
      it.restart_chain = (i == rs);
      bytes_in_flight++;
      pending_bytes.push_back(it);
    end
    stim_count += n;
    key_known = close && known;
    if (cur_mode == MODE_ENCODE) begin
      gen_key = crc;
    end else if (n >= 4) begin
      gen_key = {dec[n-3], dec[n-4]};
    end else begin
      gen_key = k;
    end
  endtask

  task automatic add_noise(input int n, input int rs);
    logic [7:0] raw [$];
    repeat (n) raw.push_back($urandom);
    push_bytes(raw, rs, 1'b1);
  endtask

  // A decode block whose trailer matches, unless one trailer bit is flipped.
  task automatic add_good(input int n, input int rs, input bit flip);
    logic [7:0]  plain [$];
    logic [7:0]  raw [$];
    logic [15:0] k;
    logic [15:0] crc;
    logic [15:0] inv;
    if (!key_known) begin
      rs = 0;
    end
    crc = (rs == 0) ? cur_start : gen_key;
    repeat (n) begin
      plain.push_back($urandom);
      crc = crc16_arc(crc, plain[$]);
    end
    inv = ~crc;
    plain.push_back(crc[7:0]);
    plain.push_back(crc[15:8]);
    plain.push_back(inv[7:0]);
    plain.push_back(inv[15:8]);
    if (flip) begin
      plain[n + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    end
    k = gen_key;
    foreach (plain[i]) begin
      if (i == rs) begin
        k = cur_start;
      end
      raw.push_back(plain[i] + k[7:0]);
    end
    push_bytes(raw, rs, 1'b1);
  endtask

  initial begin
    logic [7:0] bytes [$];
    int         target;
    int         phase_end;
    int         r;
    int         rs;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_reg(REG_MODE, {15'h0, MODE_DECODE});
    set_reg(REG_START_KEY, 16'hFFFF);
    bytes = '{8'hFF, 8'h00, 8'hFF};
    push_bytes(bytes, -1, 1'b1);
    add_good(0, 0, 1'b0);
    add_good(1, 2, 1'b0);
    add_good(0, -1, 1'b1);
    wait_idle();
    set_reg(REG_MODE, {15'h0, MODE_ENCODE});
    set_reg(REG_START_KEY, 16'h0000);
    bytes = '{8'hFF};
    push_bytes(bytes, 0, 1'b1);
    bytes = '{8'h00, 8'h80};
    push_bytes(bytes, 1, 1'b1);
    // Blocks that change mode halfway through.
    bytes = '{8'h5A};
    push_bytes(bytes, -1, 1'b0);
    wait_idle();
    set_reg(REG_MODE, {15'h0, MODE_DECODE});
    add_noise(4, -1);
    bytes = '{8'hA5, 8'h3C};
    push_bytes(bytes, -1, 1'b0);
    wait_idle();
    set_reg(REG_MODE, {15'h0, MODE_ENCODE});
    add_noise(1, -1);

    target = RandomItems;
    while (stim_count < target) begin
      wait_idle();
      set_reg(REG_MODE, {15'($urandom), 1'($urandom)});
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       set_reg(REG_START_KEY, 16'h0000);
          1:       set_reg(REG_START_KEY, 16'hFFFF);
          default: set_reg(REG_START_KEY, 16'($urandom));
        endcase
      end
      phase_end = stim_count + $urandom_range(40, 90);
      if (phase_end > target) begin
        phase_end = target;
      end
      while (stim_count < phase_end) begin
        r = $urandom_range(0, 99);
        rs = $urandom_range(0, 99);
        rs = (rs < 55) ? -1 : (rs < 85) ? 0 : $urandom_range(1, 6);
        if (cur_mode == MODE_ENCODE) begin
          add_noise((r < 90) ? $urandom_range(1, 8) : $urandom_range(9, 20), rs);
        end else if (r < 70) begin
          add_good(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6),
                   rs, 1'b0);
        end else if (r < 80) begin
          add_good($urandom_range(0, 6), rs, 1'b1);
        end else if (r < 90) begin
          add_noise($urandom_range(1, 3), rs);
        end else begin
          add_noise($urandom_range(4, 12), rs);
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
